>>> hw/rtl/tsac_pkg.sv
// shared types, constants and saturation helpers for the covariance update block
package tsac_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int VAL_BITS  = 64;
    localparam int MAG_BITS  = 62;
    localparam int PROD_BITS = 2 * MAG_BITS + 1;
    localparam int DIVN_BITS = MAG_BITS + FRAC_BITS;
    localparam int ROOT_BITS = VAL_BITS / 2;
    localparam int CNT_BITS  = $clog2(DIVN_BITS + 1);
    localparam int IDX_BITS  = 3;
    localparam int GAIN_BITS = FRAC_BITS + 1;

    typedef logic signed [VAL_BITS-1:0] t_val;

    localparam t_val LIM  = t_val'((64'sd1 <<< MAG_BITS) - 64'sd1);
    localparam t_val ONE  = t_val'(64'sd1 <<< FRAC_BITS);
    localparam t_val THREE = t_val'(3);
    localparam t_val UMAX = t_val'((64'sd1 <<< WORD_BITS) - 64'sd1);
    localparam t_val SMAX = t_val'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam t_val SMIN = t_val'(-(64'sd1 <<< (WORD_BITS - 1)));

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_IDIV,
        OP_SQRT
    } t_op;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_NOISE,
        CFG_TIME,
        CFG_PP,
        CFG_PV,
        CFG_VV
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_H2, ST_H3, ST_K1, ST_K0A, ST_K0B, ST_H3D, ST_K0C, ST_K1B, ST_K3,
        ST_RATIO, ST_SQRT, ST_OMSQ, ST_DEN, ST_N0, ST_P0, ST_N1, ST_P1, ST_P1O,
        ST_ALFO, ST_VP, ST_PP, ST_PV, ST_Q1, ST_VV, ST_FIN
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
        t_val a;
        t_val b;
    } t_alu_req;

    function automatic t_val sat_add(input t_val a, input t_val b);
        t_val s;
        s = a + b;
        if (s > LIM) return LIM;
        if (s < -LIM) return -LIM;
        return s;
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_u(input t_val x);
        if (x < 0) return '0;
        if (x > UMAX) return '1;
        return x[WORD_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_s(input t_val x);
        if (x > SMAX) return SMAX[WORD_BITS-1:0];
        if (x < SMIN) return SMIN[WORD_BITS-1:0];
        return x[WORD_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/tsac_stream_if.sv
// valid/ready channels for measurement words and result words
interface tsac_in_if import tsac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] meas_time;
    logic [WORD_BITS-1:0] var_fluct;
    logic [WORD_BITS-1:0] var_bias;

    modport source (output valid, output meas_time, output var_fluct, output var_bias,
                    input ready);
    modport sink   (input valid, input meas_time, input var_fluct, input var_bias,
                    output ready);
endinterface

interface tsac_out_if import tsac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [WORD_BITS-1:0] cov_pp;
    logic [WORD_BITS-1:0] cov_pv;
    logic [WORD_BITS-1:0] cov_vv;
    logic [GAIN_BITS-1:0] gain_pos;
    logic [WORD_BITS-1:0] gain_vel;

    modport source (output valid, output status, output cov_pp, output cov_pv,
                    output cov_vv, output gain_pos, output gain_vel, input ready);
    modport sink   (input valid, input status, input cov_pp, input cov_pv,
                    input cov_vv, input gain_pos, input gain_vel, output ready);
endinterface

>>> hw/rtl/tsac_alu.sv
// bit-serial multiply, divide and square root unit shared by the sequencer
module tsac_alu import tsac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output logic     o_done,
    output t_val     o_res
);

    logic                 r_busy, n_busy;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    t_op                  r_op, n_op;
    logic                 r_neg, n_neg;
    logic                 r_dz, n_dz;
    t_val                 r_dzres, n_dzres;
    logic [MAG_BITS-1:0]  r_b, n_b;
    logic [MAG_BITS:0]    r_hi, n_hi;
    logic [MAG_BITS-1:0]  r_lo, n_lo;
    logic [DIVN_BITS-1:0] r_n, n_n;
    logic [MAG_BITS-1:0]  r_rem, n_rem;
    logic [ROOT_BITS:0]   r_srem, n_srem;
    logic [ROOT_BITS-1:0] r_root, n_root;

    t_val                 abs_a, abs_b;
    logic [MAG_BITS-1:0]  ma, mb;
    logic [MAG_BITS+1:0]  msum;
    logic [MAG_BITS:0]    dtr, ddiff;
    logic                 dge;
    logic [ROOT_BITS+1:0] srt, trial, sdiff;
    logic                 sge;
    logic [PROD_BITS-1:0] prod;
    t_val                 mag_res;

    assign abs_a = i_req.a[VAL_BITS-1] ? -i_req.a : i_req.a;
    assign abs_b = i_req.b[VAL_BITS-1] ? -i_req.b : i_req.b;
    assign ma    = abs_a[MAG_BITS-1:0];
    assign mb    = abs_b[MAG_BITS-1:0];

    assign msum  = {1'b0, r_hi} + {2'b00, (r_lo[0] ? r_b : {MAG_BITS{1'b0}})};
    assign dtr   = {r_rem, r_n[DIVN_BITS-1]};
    assign ddiff = dtr - {1'b0, r_b};
    assign dge   = dtr >= {1'b0, r_b};
    assign srt   = {r_srem[ROOT_BITS-1:0], r_n[DIVN_BITS-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign sdiff = srt - trial;
    assign sge   = srt >= trial;
    assign prod  = {r_hi, r_lo};

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_neg   = r_neg;
        n_dz    = r_dz;
        n_dzres = r_dzres;
        n_b     = r_b;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_n     = r_n;
        n_rem   = r_rem;
        n_srem  = r_srem;
        n_root  = r_root;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_op    = i_req.op;
            n_neg   = i_req.a[VAL_BITS-1] ^ i_req.b[VAL_BITS-1];
            n_dz    = 1'b0;
            n_dzres = '0;
            n_rem   = '0;
            n_srem  = '0;
            n_root  = '0;
            n_hi    = '0;
            case (i_req.op)
                OP_MUL: begin
                    n_b   = ma;
                    n_lo  = mb;
                    n_cnt = CNT_BITS'(MAG_BITS);
                end
                OP_DIV, OP_IDIV: begin
                    n_b   = mb;
                    n_n   = (i_req.op == OP_DIV) ? {ma, {FRAC_BITS{1'b0}}}
                                                 : {{FRAC_BITS{1'b0}}, ma};
                    n_cnt = CNT_BITS'(DIVN_BITS);
                    if (i_req.b == '0) begin
                        n_dz    = 1'b1;
                        n_neg   = 1'b0;
                        n_cnt   = '0;
                        n_dzres = (i_req.a > 0) ? LIM : ((i_req.a < 0) ? -LIM : '0);
                    end
                end
                OP_SQRT: begin
                    n_neg = 1'b0;
                    n_n   = {i_req.a, {(DIVN_BITS-VAL_BITS){1'b0}}};
                    n_cnt = CNT_BITS'(ROOT_BITS);
                end
                default: n_cnt = '0;
            endcase
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                case (r_op)
                    OP_MUL: begin
                        n_hi = msum[MAG_BITS+1:1];
                        n_lo = {msum[0], r_lo[MAG_BITS-1:1]};
                    end
                    OP_DIV, OP_IDIV: begin
                        n_rem = dge ? ddiff[MAG_BITS-1:0] : dtr[MAG_BITS-1:0];
                        n_n   = {r_n[DIVN_BITS-2:0], dge};
                    end
                    OP_SQRT: begin
                        n_srem = sge ? sdiff[ROOT_BITS:0] : srt[ROOT_BITS:0];
                        n_root = {r_root[ROOT_BITS-2:0], sge};
                        n_n    = {r_n[DIVN_BITS-3:0], 2'b00};
                    end
                    default: n_cnt = '0;
                endcase
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_MUL: begin
                if (|prod[PROD_BITS-1:MAG_BITS+FRAC_BITS]) mag_res = LIM;
                else mag_res = {2'b00, prod[MAG_BITS+FRAC_BITS-1:FRAC_BITS]};
            end
            OP_DIV, OP_IDIV: begin
                if (r_dz) mag_res = r_dzres;
                else if (|r_n[DIVN_BITS-1:MAG_BITS]) mag_res = LIM;
                else mag_res = {2'b00, r_n[MAG_BITS-1:0]};
            end
            OP_SQRT: mag_res = {{(VAL_BITS-ROOT_BITS){1'b0}}, r_root};
            default: mag_res = '0;
        endcase
    end

    assign o_res  = r_neg ? -mag_res : mag_res;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_op    <= n_op;
        r_neg   <= n_neg;
        r_dz    <= n_dz;
        r_dzres <= n_dzres;
        r_b     <= n_b;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_n     <= n_n;
        r_rem   <= n_rem;
        r_srem  <= n_srem;
        r_root  <= n_root;
    end

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("alu started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_req.start |=> !r_busy)
        else $error("alu still busy after done");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_cnt != '0) |=> r_busy && (r_cnt == $past(r_cnt) - 1'b1))
        else $error("alu count skipped");

endmodule

>>> hw/rtl/two_state_alpha_covariance_update_top.sv
// top level: covariance state, sequencer and result register around the serial unit
// One measurement word in, one result word out. A word whose time does not advance
// passes through the finish state into the result register. An update runs as a chain
// of bit-serial operations on one shared unit: up to 17 multiplies, up to 6 divides
// (one of them by three) and at most one square root. The block takes a new word once
// the previous one has moved into the result register. After reset the state loads
// from the init registers before the first word is taken.
module two_state_alpha_covariance_update_top import tsac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_BITS-1:0]  i_cfg_idx,
    input  logic [WORD_BITS-1:0] i_cfg_data,
    tsac_in_if.sink              i_in,
    tsac_out_if.source           o_out
);

    t_state r_state, n_state;
    logic   r_wait, n_wait, r_load, r_err, n_err;

    logic [WORD_BITS-1:0] r_noise, r_itime, r_ipp, r_ipv, r_ivv;
    logic [WORD_BITS-1:0] r_last, n_last, r_pp, n_pp, r_pv, n_pv, r_vv, n_vv;
    logic [WORD_BITS-1:0] r_t, n_t, r_vf, n_vf, r_vb, n_vb;
    t_val r_h, n_h, r_h2, n_h2, r_h3, n_h3, r_k0, n_k0, r_k1, n_k1, r_k3, n_k3;
    t_val r_alf, n_alf, r_m, n_m, r_d, n_d, r_p0, n_p0, r_p1, n_p1, r_vp, n_vp;

    logic                 r_ov, n_ov, r_ost, n_ost;
    logic [WORD_BITS-1:0] r_opp, n_opp, r_opv, n_opv, r_ovv, n_ovv, r_ogv, n_ogv;
    logic [GAIN_BITS-1:0] r_ogp, n_ogp;

    t_alu_req req;
    logic     alu_done;
    t_val     res, om, tau, vf, vb, cpp, cpv, cvv;
    logic [WORD_BITS:0] h33;
    logic     in_acc;

    tsac_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_done  (alu_done),
        .o_res   (res)
    );

    assign i_in.ready = (r_state == ST_IDLE) && !r_load;
    assign in_acc     = i_in.valid && i_in.ready;
    assign h33        = {1'b0, i_in.meas_time} - {1'b0, r_last};
    assign om         = ONE - r_alf;
    assign tau        = {{(VAL_BITS-WORD_BITS){1'b0}}, r_noise};
    assign vf         = {{(VAL_BITS-WORD_BITS){1'b0}}, r_vf};
    assign vb         = {{(VAL_BITS-WORD_BITS){1'b0}}, r_vb};
    assign cpp        = {{(VAL_BITS-WORD_BITS){1'b0}}, r_pp};
    assign cpv        = {{(VAL_BITS-WORD_BITS){r_pv[WORD_BITS-1]}}, r_pv};
    assign cvv        = {{(VAL_BITS-WORD_BITS){1'b0}}, r_vv};

    assign o_out.valid    = r_ov;
    assign o_out.status   = r_ost;
    assign o_out.cov_pp   = r_opp;
    assign o_out.cov_pv   = r_opv;
    assign o_out.cov_vv   = r_ovv;
    assign o_out.gain_pos = r_ogp;
    assign o_out.gain_vel = r_ogv;

    always_comb begin
        n_state = r_state;
        n_err = r_err;
        n_last = r_last; n_pp = r_pp; n_pv = r_pv; n_vv = r_vv;
        n_t = r_t; n_vf = r_vf; n_vb = r_vb;
        n_h = r_h; n_h2 = r_h2; n_h3 = r_h3; n_k0 = r_k0; n_k1 = r_k1; n_k3 = r_k3;
        n_alf = r_alf; n_m = r_m; n_d = r_d; n_p0 = r_p0; n_p1 = r_p1; n_vp = r_vp;
        n_ov = r_ov && !o_out.ready;
        n_ost = r_ost; n_opp = r_opp; n_opv = r_opv; n_ovv = r_ovv;
        n_ogp = r_ogp; n_ogv = r_ogv;
        req.op = OP_MUL;
        req.a  = '0;
        req.b  = '0;
        if (r_load) begin
            n_last = r_itime; n_pp = r_ipp; n_pv = r_ipv; n_vv = r_ivv;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_t  = i_in.meas_time;
                    n_vf = i_in.var_fluct;
                    n_vb = i_in.var_bias;
                    n_p0 = '0;
                    n_p1 = '0;
                    n_h  = {{(VAL_BITS-WORD_BITS-1){1'b0}}, h33};
                    if (h33[WORD_BITS] || (h33 == '0)) begin
                        n_err   = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_err   = 1'b0;
                        n_state = ST_H2;
                    end
                end
            end
            ST_H2: begin
                req.a = r_h; req.b = r_h;
                if (alu_done) begin n_h2 = res; n_state = ST_H3; end
            end
            ST_H3: begin
                req.a = r_h2; req.b = r_h;
                if (alu_done) begin n_h3 = res; n_state = ST_K1; end
            end
            ST_K1: begin
                req.a = r_h; req.b = cvv;
                if (alu_done) begin n_k1 = sat_add(cpv, res); n_state = ST_K0A; end
            end
            ST_K0A: begin
                req.a = r_h; req.b = cpv;
                if (alu_done) begin n_k0 = sat_add(cpp, res); n_state = ST_K0B; end
            end
            ST_K0B: begin
                req.a = r_h; req.b = r_k1;
                if (alu_done) begin n_k0 = sat_add(r_k0, res); n_state = ST_H3D; end
            end
            ST_H3D: begin
                req.op = OP_IDIV; req.a = r_h3; req.b = THREE;
                if (alu_done) begin n_m = res; n_state = ST_K0C; end
            end
            ST_K0C: begin
                req.a = tau; req.b = r_m;
                if (alu_done) begin n_k0 = sat_add(r_k0, res); n_state = ST_K1B; end
            end
            ST_K1B: begin
                req.a = tau; req.b = r_h2 >>> 1;
                if (alu_done) begin n_k1 = sat_add(r_k1, res); n_state = ST_K3; end
            end
            ST_K3: begin
                req.a = tau; req.b = r_h;
                if (alu_done) begin
                    n_k3 = sat_add(cvv, res);
                    if (r_k0 <= vf) begin
                        n_alf   = ONE;
                        n_state = ST_VP;
                    end else begin
                        n_state = ST_RATIO;
                    end
                end
            end
            ST_RATIO: begin
                req.op = OP_DIV; req.a = vf; req.b = r_k0;
                if (alu_done) begin n_m = res; n_state = ST_SQRT; end
            end
            ST_SQRT: begin
                req.op = OP_SQRT; req.a = r_m <<< FRAC_BITS;
                if (alu_done) begin
                    n_alf   = res;
                    n_state = (res == ONE) ? ST_VP : ST_OMSQ;
                end
            end
            ST_OMSQ: begin
                req.a = om; req.b = om;
                if (alu_done) begin n_m = res; n_state = ST_DEN; end
            end
            ST_DEN: begin
                req.a = r_m; req.b = r_k0;
                if (alu_done) begin n_d = sat_add(res, vb); n_state = ST_N0; end
            end
            ST_N0: begin
                req.a = r_k0; req.b = om;
                if (alu_done) begin n_m = res; n_state = ST_P0; end
            end
            ST_P0: begin
                req.op = OP_DIV; req.a = r_m; req.b = r_d;
                if (alu_done) begin n_p0 = res; n_state = ST_N1; end
            end
            ST_N1: begin
                req.a = r_k1; req.b = om;
                if (alu_done) begin n_m = res; n_state = ST_P1; end
            end
            ST_P1: begin
                req.op = OP_DIV; req.a = r_m; req.b = r_d;
                if (alu_done) begin
                    n_p1    = res;
                    n_state = (r_p0 > ONE) ? ST_P1O : ST_VP;
                end
            end
            ST_P1O: begin
                req.op = OP_DIV; req.a = r_k1; req.b = r_k0;
                if (alu_done) begin n_p1 = res; n_p0 = ONE; n_state = ST_ALFO; end
            end
            ST_ALFO: begin
                req.op = OP_DIV; req.a = vf + vb; req.b = r_k0;
                if (alu_done) begin n_alf = res; n_state = ST_VP; end
            end
            ST_VP: begin
                req.a = om; req.b = r_p0;
                if (alu_done) begin n_vp = sat_add(ONE, -res); n_state = ST_PP; end
            end
            ST_PP: begin
                req.a = r_vp; req.b = r_k0;
                if (alu_done) begin n_pp = clamp_u(res); n_state = ST_PV; end
            end
            ST_PV: begin
                req.a = r_vp; req.b = r_k1;
                if (alu_done) begin n_pv = clamp_s(res); n_state = ST_Q1; end
            end
            ST_Q1: begin
                req.a = om; req.b = r_p1;
                if (alu_done) begin n_m = res; n_state = ST_VV; end
            end
            ST_VV: begin
                req.a = r_m; req.b = r_k1;
                if (alu_done) begin n_vv = clamp_u(sat_add(r_k3, -res)); n_state = ST_FIN; end
            end
            ST_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov  = 1'b1;
                    n_ost = r_err;
                    n_opp = r_pp;
                    n_opv = r_pv;
                    n_ovv = r_vv;
                    if (r_err) begin
                        n_ogp = '0;
                        n_ogv = '0;
                    end else begin
                        n_last = r_t;
                        if (r_p0 < 0) n_ogp = '0;
                        else if (r_p0 > ONE) n_ogp = ONE[GAIN_BITS-1:0];
                        else n_ogp = r_p0[GAIN_BITS-1:0];
                        n_ogv = clamp_s(r_p1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        req.start = (r_state != ST_IDLE) && (r_state != ST_FIN) && !r_wait;
        if (alu_done) n_wait = 1'b0;
        else if (req.start) n_wait = 1'b1;
        else n_wait = r_wait;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_load  <= 1'b1;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
            r_noise <= ONE[WORD_BITS-1:0];
            r_itime <= '0;
            r_ipp   <= ONE[WORD_BITS-1:0];
            r_ipv   <= '0;
            r_ivv   <= ONE[WORD_BITS-1:0];
            r_last  <= '0;
            r_pp    <= ONE[WORD_BITS-1:0];
            r_pv    <= '0;
            r_vv    <= ONE[WORD_BITS-1:0];
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_load  <= 1'b0;
            r_err   <= n_err;
            r_ov    <= n_ov;
            r_last  <= n_last;
            r_pp    <= n_pp;
            r_pv    <= n_pv;
            r_vv    <= n_vv;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NOISE: r_noise <= i_cfg_data;
                    CFG_TIME:  r_itime <= i_cfg_data;
                    CFG_PP:    r_ipp   <= i_cfg_data;
                    CFG_PV:    r_ipv   <= i_cfg_data;
                    CFG_VV:    r_ivv   <= i_cfg_data;
                    default:   r_noise <= r_noise;
                endcase
            end
        end
        r_t   <= n_t;   r_vf  <= n_vf;  r_vb  <= n_vb;
        r_h   <= n_h;   r_h2  <= n_h2;  r_h3  <= n_h3;
        r_k0  <= n_k0;  r_k1  <= n_k1;  r_k3  <= n_k3;
        r_alf <= n_alf; r_m   <= n_m;   r_d   <= n_d;
        r_p0  <= n_p0;  r_p1  <= n_p1;  r_vp  <= n_vp;
        r_ost <= n_ost; r_opp <= n_opp; r_opv <= n_opv; r_ovv <= n_ovv;
        r_ogp <= n_ogp; r_ogv <= n_ogv;
    end

    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_wait)
        else $error("sequencer idle with operation pending");
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> r_wait)
        else $error("alu result without request");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == ST_FIN))
        else $error("result word loaded outside finish");

endmodule

>>> tb/sv/tb_two_state_alpha_covariance_update_top.sv
// testbench: random and directed measurement words against a bit-true covariance predictor
module tb_two_state_alpha_covariance_update_top import tsac_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QLIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint QONE = 64'sd65536;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic                 status;
        logic [WORD_BITS-1:0] cov_pp;
        logic [WORD_BITS-1:0] cov_pv;
        logic [WORD_BITS-1:0] cov_vv;
        logic [GAIN_BITS-1:0] gain_pos;
        logic [WORD_BITS-1:0] gain_vel;
    } t_cov_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_BITS-1:0]  i_cfg_idx;
    logic [WORD_BITS-1:0] i_cfg_data;

    tsac_in_if  meas_ch();
    tsac_out_if res_ch();

    two_state_alpha_covariance_update_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (meas_ch.sink),
        .o_out      (res_ch.source)
    );

    // predictor state and registers
    logic [WORD_BITS-1:0] noise_reg;
    logic [WORD_BITS-1:0] init_regs [1:4];
    logic [WORD_BITS-1:0] prev_time;
    longint               est_pp, est_pv, est_vv;

    t_cov_result pending_results[$];
    int  errors;
    int  words_sent, words_checked, stale_words, cfg_writes;
    int  cycles = 0;
    bit  idle_on;
    int  hold_request;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint qsat(longint x);
        if (x > QLIM) return QLIM;
        if (x < -QLIM) return -QLIM;
        return x;
    endfunction

    function automatic longint qmag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        longint r;
        p = {64'd0, qmag(a)} * {64'd0, qmag(b)};
        p = p >> FRAC_BITS;
        r = (p > 128'(QLIM)) ? QLIM : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint qdiv(longint a, longint b);
        logic [127:0] q;
        longint r;
        if (b == 0) return (a > 0) ? QLIM : ((a < 0) ? -QLIM : 64'sd0);
        q = ({64'd0, qmag(a)} << FRAC_BITS) / {64'd0, qmag(b)};
        r = (q > 128'(QLIM)) ? QLIM : longint'(q[63:0]);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] res, bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clip_u(longint x);
        if (x < 0) return 0;
        if (x > 64'sh0_FFFF_FFFF) return 64'sh0_FFFF_FFFF;
        return x;
    endfunction

    function automatic longint clip_s(longint x);
        if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) return -64'sh8000_0000;
        return x;
    endfunction

    function automatic t_cov_result update_estimate(logic [31:0] t, logic [31:0] vf_w,
                                                    logic [31:0] vb_w);
        t_cov_result r;
        longint vf, vb, tau, h, h2, h3, k0, k1, k3, alf, om, p0, p1, d, vp, gv;
        vf = longint'({32'd0, vf_w});
        vb = longint'({32'd0, vb_w});
        tau = longint'({32'd0, noise_reg});
        h = longint'({32'd0, t}) - longint'({32'd0, prev_time});
        p0 = 0;
        p1 = 0;
        if (h <= 0) begin
            r.status = 1'b1;
            r.cov_pp = est_pp[31:0];
            r.cov_pv = est_pv[31:0];
            r.cov_vv = est_vv[31:0];
            r.gain_pos = '0;
            r.gain_vel = '0;
            return r;
        end
        h2 = qmul(h, h);
        h3 = qmul(h2, h);
        k1 = qsat(est_pv + qmul(h, est_vv));
        k0 = qsat(qsat(est_pp + qmul(h, est_pv)) + qmul(h, k1));
        k0 = qsat(k0 + qmul(tau, h3 / 3));
        k1 = qsat(k1 + qmul(tau, h2 / 2));
        k3 = qsat(est_vv + qmul(tau, h));
        if (k0 <= vf) begin
            alf = QONE;
        end else begin
            alf = longint'(floor_root(64'(qdiv(vf, k0)) << FRAC_BITS));
        end
        om = QONE - alf;
        if (om != 0) begin
            d = qsat(qmul(qmul(om, om), k0) + vb);
            p0 = qdiv(qmul(k0, om), d);
            p1 = qdiv(qmul(k1, om), d);
            if (p0 > QONE) begin
                p0 = QONE;
                p1 = qdiv(k1, k0);
                alf = qdiv(vf + vb, k0);
                om = QONE - alf;
            end
        end
        vp = qsat(QONE - qmul(om, p0));
        est_pp = clip_u(qmul(vp, k0));
        est_pv = clip_s(qmul(vp, k1));
        est_vv = clip_u(qsat(k3 - qmul(qmul(om, p1), k1)));
        prev_time = t;
        if (p0 < 0) p0 = 0;
        if (p0 > QONE) p0 = QONE;
        gv = clip_s(p1);
        r.status = 1'b0;
        r.cov_pp = est_pp[31:0];
        r.cov_pv = est_pv[31:0];
        r.cov_vv = est_vv[31:0];
        r.gain_pos = p0[GAIN_BITS-1:0];
        r.gain_vel = gv[31:0];
        return r;
    endfunction

    // receiver: random stalls plus one long hold on request
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %h actual %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_cov_result e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                chk("status", 64'(e.status), 64'(res_ch.status));
                chk("cov_pp", 64'(e.cov_pp), 64'(res_ch.cov_pp));
                chk("cov_pv", 64'(e.cov_pv), 64'(res_ch.cov_pv));
                chk("cov_vv", 64'(e.cov_vv), 64'(res_ch.cov_vv));
                chk("gain_pos", 64'(e.gain_pos), 64'(res_ch.gain_pos));
                chk("gain_vel", 64'(e.gain_vel), 64'(res_ch.gain_vel));
                words_checked++;
                if (e.status) stale_words++;
            end
        end
    end

    task automatic send_meas(logic [31:0] t, logic [31:0] vf, logic [31:0] vb);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        meas_ch.valid <= 1'b1;
        meas_ch.meas_time <= t;
        meas_ch.var_fluct <= vf;
        meas_ch.var_bias <= vb;
        do @(posedge i_clk); while (!meas_ch.ready);
        pending_results.push_back(update_estimate(t, vf, vb));
        words_sent++;
    endtask

    task automatic wait_drain();
        meas_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] noise, logic [31:0] t0, logic [31:0] pp,
                              logic [31:0] pv, logic [31:0] vv);
        logic [31:0] vals [5];
        vals = '{noise, t0, pp, pv, vv};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= IDX_BITS'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            if (t_cfg_idx'(i) == CFG_NOISE) noise_reg = vals[i];
            else init_regs[i] = vals[i];
            cfg_writes++;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return '0;
            default: return $urandom >> $urandom_range(4, 31);
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] t;
        int sel;
        sel = $urandom_range(0, 29);
        if (sel < 3) t = prev_time - $urandom_range(0, 300);
        else if (sel == 3) t = prev_time + $urandom_range(1, 24'hFF_FFFF);
        else if (sel < 8) t = prev_time + $urandom_range(1, 64);
        else t = prev_time + $urandom_range(1, 18'h3_FFFF);
        send_meas(t, rand_var(), rand_var());
    endtask

    task automatic test_reset_state();
        send_meas(32'd0, 32'd0, 32'd0);
        send_meas(32'd1, 32'd0, 32'd0);
        send_meas(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_meas(32'd0, 32'd5, 32'd5);
    endtask

    task automatic test_field_extremes();
        send_meas(prev_time + 32'h1_0000, 32'hFFFF_FFFF, 32'd0);
        send_meas(prev_time + 32'h1_0000, 32'd0, 32'hFFFF_FFFF);
        send_meas(prev_time + 32'h2_0000, 32'd0, 32'd0);
        send_meas(prev_time + 32'h8000, 32'hF000, 32'd0);
        send_meas(prev_time + 32'h8000, 32'hFFFF, 32'd1);
        send_meas(prev_time + 32'h10_0000, 32'h1_0000, 32'h100);
        send_meas(prev_time + 32'd1, 32'h5555_5555, 32'hAAAA_AAAA);
        send_meas(prev_time + 32'd1, 32'hAAAA_AAAA, 32'h5555_5555);
        send_meas(prev_time, 32'd7, 32'd7);
    endtask

    task automatic test_noise_settings();
        logic [31:0] levels [4];
        levels = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000};
        foreach (levels[i]) begin
            wait_drain();
            set_config(levels[i], $urandom, $urandom, $urandom, $urandom);
            repeat (3) send_random();
        end
    endtask

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 99) begin
                wait_drain();
                set_config($urandom >> $urandom_range(8, 24), $urandom, $urandom,
                           $urandom, $urandom);
            end
            send_random();
        end
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_request = 4000;
        repeat (6) send_random();
    endtask

    task automatic test_time_top();
        send_meas(32'h8000_0000 + ($urandom & 32'h7FFF_FFFF), rand_var(), rand_var());
        send_meas(32'hFFFF_FFFF, $urandom, $urandom);
        send_meas(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_meas(32'h7FFF_FFFF, 32'd1, 32'd1);
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        stale_words = 0;
        cfg_writes = 0;
        idle_on = 1'b1;
        hold_request = 0;
        noise_reg = 32'h0001_0000;
        init_regs = '{32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000};
        prev_time = 32'd0;
        est_pp = QONE;
        est_pv = 0;
        est_vv = QONE;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        meas_ch.valid <= 1'b0;
        meas_ch.meas_time <= '0;
        meas_ch.var_fluct <= '0;
        meas_ch.var_bias <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        test_reset_state();
        test_field_extremes();
        test_noise_settings();
        test_random_stream(380);
        test_backpressure();
        wait_drain();
        idle_on = 1'b0;
        set_config(32'h0000_4000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
        test_random_stream(120);
        test_time_top();

        wait_drain();
        repeat (1500) @(posedge i_clk);
        $display("sent %0d measurement words, checked %0d results (%0d stale-time)",
                 words_sent, words_checked, stale_words);
        $display("%0d register writes, noise levels from zero to full scale, one long stall",
                 cfg_writes);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
